/* design/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

/* design/lmn_pkg.sv */
// Shared types and codes of the Lamport mutual exclusion node.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
package lmn_pkg;

   localparam int ID_W     = 4;
   localparam int TIME_W   = 15;
   localparam int OP_W     = 3;
   localparam int ACTION_W = 2;
   localparam int ERR_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [TIME_W-1:0] CLOCK_MAX = 15'd32767;

   // Input opcodes.
   localparam logic [OP_W-1:0] OP_LOCAL_REQ  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOCAL_REL  = 3'd1;
   localparam logic [OP_W-1:0] OP_RECV_REQ   = 3'd2;
   localparam logic [OP_W-1:0] OP_RECV_REPLY = 3'd3;
   localparam logic [OP_W-1:0] OP_RECV_REL   = 3'd4;
   localparam logic [OP_W-1:0] OP_RECV_OTHER = 3'd5;

   // Result actions.
   localparam logic [ACTION_W-1:0] ACT_NONE      = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MCAST_REQ = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REPLY     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_MCAST_REL = 2'd3;

   // Result error codes.
   localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NOT_HEAD = 3'd2;
   localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd3;
   localparam logic [ERR_W-1:0] ERR_FULL     = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_COUNT = 2'd1;

   typedef struct packed {
      logic [ID_W-1:0]   node;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                latch_in;
      logic                merge;
      logic                tick;
      logic                push_own;
      logic                push_src;
      logic                scan_start;
      logic                pop_read;
      logic                pop_write;
      logic                reply_clr;
      logic                reply_inc;
      logic                wait_set;
      logic                wait_clr;
      logic                set_action;
      logic [ACTION_W-1:0] action;
      logic                set_err;
      logic [ERR_W-1:0]    err;
      logic                set_grant;
      logic                out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            waiting;
      logic            reply_ok;
      logic            scan_done;
      logic            head_is_own;
      logic            head_is_src;
   } dp_status_type;

endpackage

/* design/lmn_datapath.sv */
// Datapath of the Lamport mutual exclusion node: Lamport clock, request queue memory
// with a sequential head search, reply counter, configuration and result registers.
// Depends on lmn_pkg.
module lmn_datapath import lmn_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [ID_W-1:0]      req_src_id,
   input  logic [TIME_W-1:0]    req_msg_time,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ID_W-1:0]      csr_data,
   output logic [ACTION_W-1:0]  rsp_action,
   output logic [ID_W-1:0]      rsp_dest_id,
   output logic [TIME_W-1:0]    rsp_stamp,
   output logic                 rsp_granted,
   output logic [ERR_W-1:0]     rsp_error
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] x);
      sat_inc = (x == CLOCK_MAX) ? x : x + TIME_W'(1);
   endfunction

   // Configuration.
   logic [ID_W-1:0] own_id_ff, peer_count_ff;

   // Latched input item.
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   src_ff;
   logic [TIME_W-1:0] mt_ff;

   // Node state.
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [3:0]        reply_ff, reply_in;
   logic              waiting_ff, waiting_in;

   // Queue memory.
   entry_type         mem [QUEUE_DEPTH];
   entry_type         rdata_ff;
   logic              mem_we;
   logic [IW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data;

   // Head search.
   logic              busy_ff, busy_in;
   logic [IW-1:0]     scan_addr_ff, scan_addr_in;
   logic              cmp_valid_ff;
   logic              cmp_last_ff;
   logic [IW-1:0]     cmp_idx_ff;
   logic              done_ff;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   entry_type         best_ff, best_in;
   logic [CW-1:0]     last_cnt;
   logic [IW-1:0]     last_idx;
   logic              scan_last;

   // Working result.
   logic [ACTION_W-1:0] action_ff;
   logic [ID_W-1:0]     dest_ff;
   logic [TIME_W-1:0]   stamp_ff;
   logic                granted_ff;
   logic [ERR_W-1:0]    err_ff;

   assign last_cnt  = count_ff - CW'(1);
   assign last_idx  = last_cnt[IW-1:0];
   assign scan_last = (scan_addr_ff == last_idx);

   always_comb begin
      clock_in = clock_ff;
      if (cmd.merge) begin
         clock_in = sat_inc((mt_ff > clock_ff) ? mt_ff : clock_ff);
      end else if (cmd.tick) begin
         clock_in = sat_inc(clock_ff);
      end
   end

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = count_ff[IW-1:0];
      wr_data = '{node: own_id_ff, stamp: clock_in};
      count_in = count_ff;
      if (cmd.push_own) begin
         mem_we   = 1'b1;
         count_in = count_ff + CW'(1);
      end else if (cmd.push_src) begin
         mem_we   = 1'b1;
         wr_data  = '{node: src_ff, stamp: mt_ff};
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_write) begin
         // The last entry moves into the hole left by the head.
         mem_we   = 1'b1;
         wr_addr  = best_idx_ff;
         wr_data  = rdata_ff;
         count_in = last_cnt;
      end
      rd_addr = cmd.pop_read ? last_idx : scan_addr_ff;
   end

   always_comb begin
      reply_in = reply_ff;
      if (cmd.reply_clr) begin
         reply_in = '0;
      end else if (cmd.reply_inc && reply_ff != 4'hF) begin
         reply_in = reply_ff + 4'd1;
      end
      waiting_in = waiting_ff;
      if (cmd.wait_set) begin
         waiting_in = 1'b1;
      end else if (cmd.wait_clr) begin
         waiting_in = 1'b0;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_start) begin
         busy_in      = 1'b1;
         scan_addr_in = '0;
      end else if (busy_ff) begin
         if (scan_last) begin
            busy_in = 1'b0;
         end else begin
            scan_addr_in = scan_addr_ff + IW'(1);
         end
      end
      // Strict compare keeps the first of equal entries in storage order.
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (cmp_valid_ff) begin
         if (cmp_idx_ff == '0 || rdata_ff.stamp < best_ff.stamp ||
             (rdata_ff.stamp == best_ff.stamp && rdata_ff.node < best_ff.node)) begin
            best_in     = rdata_ff;
            best_idx_in = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= 4'd1;
         peer_count_ff <= 4'd0;
         clock_ff      <= '0;
         count_ff      <= '0;
         reply_ff      <= '0;
         waiting_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         cmp_last_ff   <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_OWN_ID) begin
            own_id_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_PEER_COUNT) begin
            peer_count_ff <= csr_data;
         end
         clock_ff     <= clock_in;
         count_ff     <= count_in;
         reply_ff     <= reply_in;
         waiting_ff   <= waiting_in;
         busy_ff      <= busy_in;
         cmp_valid_ff <= busy_ff;
         cmp_last_ff  <= busy_ff && scan_last;
         done_ff      <= cmp_valid_ff && cmp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= scan_addr_ff;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      if (cmd.latch_in) begin
         op_ff      <= req_opcode;
         src_ff     <= req_src_id;
         mt_ff      <= req_msg_time;
         action_ff  <= ACT_NONE;
         dest_ff    <= '0;
         stamp_ff   <= '0;
         granted_ff <= 1'b0;
         err_ff     <= ERR_OK;
      end
      if (cmd.set_action) begin
         action_ff <= cmd.action;
         stamp_ff  <= clock_in;
         dest_ff   <= (cmd.action == ACT_REPLY) ? src_ff : '0;
      end
      if (cmd.set_err) begin
         err_ff <= cmd.err;
      end
      if (cmd.set_grant) begin
         granted_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         rsp_action  <= action_ff;
         rsp_dest_id <= dest_ff;
         rsp_stamp   <= stamp_ff;
         rsp_granted <= granted_ff;
         rsp_error   <= err_ff;
      end
   end

   assign status.op          = op_ff;
   assign status.empty       = (count_ff == '0);
   assign status.full        = (count_ff >= CW'(QUEUE_DEPTH));
   assign status.waiting     = waiting_ff;
   assign status.reply_ok    = (reply_ff >= peer_count_ff);
   assign status.scan_done   = done_ff;
   assign status.head_is_own = (best_ff.node == own_id_ff);
   assign status.head_is_src = (best_ff.node == src_ff);

endmodule

/* design/lmn_ctrl.sv */
// Controller of the Lamport mutual exclusion node: sequences each event through
// the datapath and owns the input and result handshakes. Depends on lmn_pkg.
module lmn_ctrl import lmn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_RREQ_TICK,
      S_LREL_SCAN,
      S_LREL_POP,
      S_RREL_SCAN,
      S_RREL_POP,
      S_GCHK,
      S_GSCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_in = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.op)
               OP_LOCAL_REQ: begin
                  if (status.full) begin
                     // A refused request can still see a grant that is now due.
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_FULL;
                     state_in    = S_GCHK;
                  end else begin
                     cmd.tick       = 1'b1;
                     cmd.set_action = 1'b1;
                     cmd.action     = ACT_MCAST_REQ;
                     cmd.push_own   = 1'b1;
                     cmd.reply_clr  = 1'b1;
                     cmd.wait_set   = 1'b1;
                     state_in       = S_GCHK;
                  end
               end
               OP_LOCAL_REL: begin
                  if (status.empty) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_EMPTY;
                     state_in    = S_DONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_LREL_SCAN;
                  end
               end
               OP_RECV_REQ: begin
                  cmd.merge = 1'b1;
                  if (status.full) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_FULL;
                     state_in    = S_GCHK;
                  end else begin
                     cmd.push_src = 1'b1;
                     state_in     = S_RREQ_TICK;
                  end
               end
               OP_RECV_REPLY: begin
                  cmd.merge     = 1'b1;
                  cmd.reply_inc = 1'b1;
                  state_in      = S_GCHK;
               end
               OP_RECV_REL: begin
                  cmd.merge = 1'b1;
                  if (status.empty) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_EMPTY;
                     state_in    = S_GCHK;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_RREL_SCAN;
                  end
               end
               OP_RECV_OTHER: begin
                  cmd.merge = 1'b1;
                  state_in  = S_GCHK;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RREQ_TICK: begin
            cmd.tick       = 1'b1;
            cmd.set_action = 1'b1;
            cmd.action     = ACT_REPLY;
            state_in       = S_GCHK;
         end
         S_LREL_SCAN: begin
            if (status.scan_done) begin
               if (status.head_is_own) begin
                  cmd.pop_read = 1'b1;
                  state_in     = S_LREL_POP;
               end else begin
                  cmd.set_err = 1'b1;
                  cmd.err     = ERR_NOT_HEAD;
                  state_in    = S_DONE;
               end
            end
         end
         S_LREL_POP: begin
            cmd.pop_write  = 1'b1;
            cmd.tick       = 1'b1;
            cmd.set_action = 1'b1;
            cmd.action     = ACT_MCAST_REL;
            cmd.wait_clr   = 1'b1;
            state_in       = S_DONE;
         end
         S_RREL_SCAN: begin
            if (status.scan_done) begin
               if (status.head_is_src) begin
                  cmd.pop_read = 1'b1;
                  state_in     = S_RREL_POP;
               end else begin
                  cmd.set_err = 1'b1;
                  cmd.err     = ERR_MISMATCH;
                  state_in    = S_GCHK;
               end
            end
         end
         S_RREL_POP: begin
            cmd.pop_write = 1'b1;
            state_in      = S_GCHK;
         end
         S_GCHK: begin
            // The head is searched again only when a grant is possible.
            if (status.waiting && status.reply_ok && !status.empty) begin
               cmd.scan_start = 1'b1;
               state_in       = S_GSCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_GSCAN: begin
            if (status.scan_done) begin
               if (status.head_is_own) begin
                  cmd.set_grant = 1'b1;
                  cmd.wait_clr  = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/lamport_mutex_node.sv */
// An event is executed, checked for a grant where needed, and its result loaded;
// each head search over the queued entries adds a scan, and a remote release may need two.
// Throughput: one event at a time, taken the cycle after the previous result is loaded.
// A finished result waits in the output register while the next event is taken.
// Reset: synchronous, active high; clears clock, queue count, reply count, waiting flag
// and the handshakes, and sets own_id to 1 and peer_count to 0.
module lamport_mutex_node import lmn_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [ID_W-1:0]      req_src_id,
   input  logic [TIME_W-1:0]    req_msg_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ACTION_W-1:0]  rsp_action,
   output logic [ID_W-1:0]      rsp_dest_id,
   output logic [TIME_W-1:0]    rsp_stamp,
   output logic                 rsp_granted,
   output logic [ERR_W-1:0]     rsp_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ID_W-1:0]      csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   lmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lmn_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_opcode   (req_opcode),
      .req_src_id   (req_src_id),
      .req_msg_time (req_msg_time),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_action   (rsp_action),
      .rsp_dest_id  (rsp_dest_id),
      .rsp_stamp    (rsp_stamp),
      .rsp_granted  (rsp_granted),
      .rsp_error    (rsp_error)
   );

endmodule

/* design/lmn_checker.sv */
// Port-level checks of the Lamport mutual exclusion node, bound to its top level.
// Depends on lmn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lmn_checker import lmn_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ACTION_W-1:0]  rsp_action,
   input logic [ID_W-1:0]      rsp_dest_id,
   input logic [TIME_W-1:0]    rsp_stamp,
   input logic                 rsp_granted,
   input logic [ERR_W-1:0]     rsp_error
);

   // A stalled result keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_action) && $stable(rsp_dest_id) && $stable(rsp_stamp) &&
      $stable(rsp_granted) && $stable(rsp_error))

   // Only one event is in work at a time.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // A failed event never sends a message.
   `ASSERT_IMP(a_err_no_send, clock, reset, rsp_valid && rsp_error != ERR_OK,
      rsp_action == ACT_NONE)

   // Stamp and destination are zero unless a message goes out of the matching kind.
   `ASSERT_IMP(a_fields_zero, clock, reset, rsp_valid && rsp_action != ACT_REPLY,
      rsp_dest_id == '0 && (rsp_action != ACT_NONE || rsp_stamp == '0))

endmodule

bind lamport_mutex_node lmn_checker u_lmn_checker (.*);
